// ===== src/swsa_pkg.sv =====
// Package with shared types and constants of the sliding window statistics block.
package swsa_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = SAMPLE_W + COUNT_W;
    localparam int DIV_STEP_W = 6;

    // Configuration register indexes.
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [1:0] REG_ALARM_ON    = 2'd1;
    localparam logic [1:0] REG_ALARM_OFF   = 2'd2;

    typedef struct packed {
        logic [7:0]               src_id;
        logic [7:0]               quality;
        logic [31:0]              event_time;
        logic signed [SAMPLE_W-1:0] sample_value;
    } event_t;

    typedef struct packed {
        logic [7:0]               last_src_id;
        logic [7:0]               last_quality;
        logic [31:0]              last_event_time;
        logic signed [SAMPLE_W-1:0] window_minimum;
        logic signed [SAMPLE_W-1:0] window_maximum;
        logic signed [SAMPLE_W-1:0] window_mean;
        logic [COUNT_W-1:0]       samples_in_window;
        logic                     alarm_raised;
    } result_t;

    // Control shared by all cells of the sample chain.
    typedef struct packed {
        logic shift_in;
        logic rotate;
    } chain_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUB,
        ST_DIV
    } state_t;

endpackage

// ===== src/swsa_if.sv =====
// Valid/ready channel interfaces for events and results.
interface swsa_evt_if;
    import swsa_pkg::*;
    logic   valid;
    logic   ready;
    event_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swsa_res_if;
    import swsa_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/swsa_cell.sv =====
// One cell of the sample chain: shifts forward on insert, backward on rotate.
module swsa_cell (
    input  logic                               clk,
    input  swsa_pkg::chain_ctl_t               ctl,
    input  logic signed [swsa_pkg::SAMPLE_W-1:0] prev_value,
    input  logic signed [swsa_pkg::SAMPLE_W-1:0] next_value,
    output logic signed [swsa_pkg::SAMPLE_W-1:0] value
);
    import swsa_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        if (ctl.shift_in)
        begin
            value_reg <= prev_value;
        end
        else if (ctl.rotate)
        begin
            value_reg <= next_value;
        end
    end

    assign value = value_reg;
endmodule

// ===== src/swsa_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module swsa_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swsa_pkg::SUM_W-1:0]    dividend,
    input  logic [swsa_pkg::COUNT_W-1:0]  divisor,
    output logic                          done,
    output logic [swsa_pkg::SUM_W-1:0]    quotient
);
    import swsa_pkg::*;

    logic [SUM_W-1:0]      quot_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]    div_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [COUNT_W:0]      trial;

    // Shifted partial remainder with the next dividend bit.
    assign trial = {rem_reg, quot_reg[SUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of one division step; the remainder stays below the divisor.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg  <= COUNT_W'(trial - {1'b0, div_reg});
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= trial[COUNT_W-1:0];
                quot_reg <= {quot_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule

// ===== src/sliding_window_stats_alarm_top.sv =====
// Top level of the sliding window min/max/mean statistics block with alarm.
//
//  Channel  Direction  Handshake        Carries
//  evt      in         valid/ready      src_id, quality, event_time, sample_value
//  res      out        valid/ready      tag copy, window min/max/mean, count, alarm
//  apb      in         psel/penable     window_size, alarm_on_level, alarm_off_level
//
// An event with nonzero quality produces its result in the next cycle.
// A valid sample passes these steps until its result is valid: accept, one full
// rotation of the cell chain for the min/max scan, the eviction update, the divider
// load, 39 restoring divider steps and the result update.
// One event is in work at a time; ready is low until its result is taken, so a new
// event is accepted only after the result of the last one has been taken.
// Reset (rst_n, asynchronous) and writes to registers 0 to 2 clear all statistics.
module sliding_window_stats_alarm_top #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    swsa_evt_if.sink    evt,
    swsa_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swsa_pkg::*;

    localparam int KW = $clog2(WINDOW_DEPTH + 1);

    // Configuration registers.
    logic [COUNT_W-1:0]         window_size_reg;
    logic signed [SAMPLE_W-1:0] alarm_on_reg;
    logic signed [SAMPLE_W-1:0] alarm_off_reg;
    logic                       cfg_write;
    logic                       cfg_hit;

    // Control and statistics state.
    state_t                     state_reg;
    state_t                     state_next;
    logic [KW-1:0]              scan_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [COUNT_W-1:0]         fill_reg;
    logic signed [SAMPLE_W-1:0] held_min_reg;
    logic signed [SAMPLE_W-1:0] held_max_reg;
    logic signed [SAMPLE_W-1:0] held_mean_reg;
    logic                       alarm_reg;
    logic [7:0]                 tag_id_reg;
    logic [7:0]                 tag_quality_reg;
    logic [31:0]                tag_stamp_reg;
    logic signed [SAMPLE_W-1:0] lo_reg;
    logic signed [SAMPLE_W-1:0] hi_reg;
    logic signed [SAMPLE_W-1:0] evict_reg;
    logic                       evict_flag_reg;
    logic                       neg_reg;
    logic                       div_go_reg;
    logic                       out_valid_reg;
    result_t                    res_reg;

    logic [COUNT_W-1:0]         eff_size;
    logic                       accept;
    logic                       div_start;
    logic                       div_done;
    logic [SUM_W-1:0]           mag;
    logic [SUM_W-1:0]           dividend;
    logic [SUM_W-1:0]           quotient;
    logic signed [SAMPLE_W-1:0] mean_value;
    chain_ctl_t                 chain_ctl;
    logic signed [SAMPLE_W-1:0] cell_value [WINDOW_DEPTH];

    // APB register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_hit   = cfg_write && (paddr[3:2] != 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= COUNT_W'(64);
            alarm_on_reg    <= '0;
            alarm_off_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_WINDOW_SIZE: window_size_reg <= pwdata[COUNT_W-1:0];
                REG_ALARM_ON:    alarm_on_reg    <= pwdata;
                REG_ALARM_OFF:   alarm_off_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WINDOW_SIZE: prdata = {{(32-COUNT_W){1'b0}}, window_size_reg};
            REG_ALARM_ON:    prdata = alarm_on_reg;
            REG_ALARM_OFF:   prdata = alarm_off_reg;
            default:         prdata = '0;
        endcase
    end

    // Effective window size, clamped to one and to the chain length.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_size = COUNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_DEPTH)
        begin
            eff_size = COUNT_W'(WINDOW_DEPTH);
        end
        else
        begin
            eff_size = window_size_reg;
        end
    end

    assign evt.ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = evt.valid && evt.ready;

    // Chain control: insert on a valid sample, rotate while scanning.
    always_comb
    begin
        chain_ctl.shift_in = accept && (evt.data.quality == 8'd0);
        chain_ctl.rotate   = (state_reg == ST_SCAN);
    end

    // Row of sample cells; rotation of the full row restores the order.
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic signed [SAMPLE_W-1:0] prev_v;
        logic signed [SAMPLE_W-1:0] next_v;
        if (i == 0)
        begin : g_head
            assign prev_v = evt.data.sample_value;
        end
        else
        begin : g_body
            assign prev_v = cell_value[i-1];
        end
        assign next_v = cell_value[(i + 1) % WINDOW_DEPTH];
        swsa_cell u_cell (
            .clk        (clk),
            .ctl        (chain_ctl),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_value[i])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (evt.data.quality == 8'd0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (int'(scan_reg) == WINDOW_DEPTH - 1)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: the divider starts once the eviction has updated the sum.
    always_comb
    begin
        div_start = div_go_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Divider launch, in the cycle after the eviction update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_go_reg <= 1'b0;
        end
        else
        begin
            div_go_reg <= (state_reg == ST_SUB);
        end
    end

    // Mean operands: magnitude plus half the count for rounding.
    assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dividend = mag + SUM_W'(fill_reg >> 1);

    swsa_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign mean_value = neg_reg ? -SAMPLE_W'(quotient) : SAMPLE_W'(quotient);

    // Statistics state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            fill_reg        <= '0;
            held_min_reg    <= '0;
            held_max_reg    <= '0;
            held_mean_reg   <= '0;
            alarm_reg       <= 1'b0;
            tag_id_reg      <= '0;
            tag_quality_reg <= '0;
            tag_stamp_reg   <= '0;
            out_valid_reg   <= 1'b0;
            scan_reg        <= '0;
            evict_flag_reg  <= 1'b0;
        end
        else if (cfg_hit)
        begin
            sum_reg         <= '0;
            fill_reg        <= '0;
            held_min_reg    <= '0;
            held_max_reg    <= '0;
            held_mean_reg   <= '0;
            alarm_reg       <= 1'b0;
            tag_id_reg      <= '0;
            tag_quality_reg <= '0;
            tag_stamp_reg   <= '0;
        end
        else
        begin
            // A waiting result blocks new events, so this never meets a new set.
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        tag_id_reg      <= evt.data.src_id;
                        tag_quality_reg <= evt.data.quality;
                        tag_stamp_reg   <= evt.data.event_time;
                        if (evt.data.quality == 8'd0)
                        begin
                            sum_reg        <= sum_reg + SUM_W'(evt.data.sample_value);
                            evict_flag_reg <= (fill_reg >= eff_size);
                            if (fill_reg < eff_size)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            scan_reg <= '0;
                            if (!alarm_reg && (evt.data.sample_value >= alarm_on_reg))
                            begin
                                alarm_reg <= 1'b1;
                            end
                            else if (alarm_reg && (evt.data.sample_value <= alarm_off_reg))
                            begin
                                alarm_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        held_min_reg  <= lo_reg;
                        held_max_reg  <= hi_reg;
                        held_mean_reg <= mean_value;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    if (evict_flag_reg)
                    begin
                        sum_reg <= sum_reg - SUM_W'(evict_reg);
                    end
                end
            endcase
        end
    end

    // Scan datapath: the head cell shows original entry scan_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evict_reg <= cell_value[WINDOW_DEPTH-1];
        end
        else if (state_reg == ST_SCAN)
        begin
            if (scan_reg == '0)
            begin
                lo_reg <= cell_value[0];
                hi_reg <= cell_value[0];
            end
            else if (int'(scan_reg) < int'(fill_reg))
            begin
                if (cell_value[0] < lo_reg)
                begin
                    lo_reg <= cell_value[0];
                end
                if (cell_value[0] > hi_reg)
                begin
                    hi_reg <= cell_value[0];
                end
            end
            if ((int'(scan_reg) == int'(eff_size)) && (int'(eff_size) < WINDOW_DEPTH))
            begin
                evict_reg <= cell_value[0];
            end
        end
        if (div_go_reg)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
    end

    // Result payload follows the held state.
    always_comb
    begin
        res_reg.last_src_id       = tag_id_reg;
        res_reg.last_quality      = tag_quality_reg;
        res_reg.last_event_time   = tag_stamp_reg;
        res_reg.window_minimum    = held_min_reg;
        res_reg.window_maximum    = held_max_reg;
        res_reg.window_mean       = held_mean_reg;
        res_reg.samples_in_window = fill_reg;
        res_reg.alarm_raised      = alarm_reg;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = res_reg;
endmodule
